@@ rtl/rlst_pkg.sv @@
// ----------------------------------------------------------------------------
// rlst_pkg
// Types and codes shared by the run length style table and its channels.
// ----------------------------------------------------------------------------
package rlst_pkg;

    localparam int FUNC_W  = 2;
    localparam int COL_W   = 12;
    localparam int STYLE_W = 6;
    localparam int LEN_W   = 16;
    localparam int USED_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_OVERLAY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

    localparam logic ST_DONE     = 1'b0;
    localparam logic ST_REJECTED = 1'b1;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [COL_W-1:0]   position;
        logic [COL_W-1:0]   span;
        logic [STYLE_W-1:0] style_in;
    } t_in_item;

    typedef struct packed {
        logic [STYLE_W-1:0] style_out;
        logic               status;
        logic [USED_W-1:0]  runs_used;
    } t_out_item;

    typedef struct packed {
        logic [STYLE_W-1:0] style;
        logic [LEN_W-1:0]   len;
    } t_run;

endpackage

@@ rtl/rlst_in_if.sv @@
// ----------------------------------------------------------------------------
// rlst_in_if
// Request channel: one operation per transaction.
// ----------------------------------------------------------------------------
interface rlst_in_if;
    logic               valid;
    logic               ready;
    rlst_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/rlst_out_if.sv @@
// ----------------------------------------------------------------------------
// rlst_out_if
// Result channel: one result per transaction.
// ----------------------------------------------------------------------------
interface rlst_out_if;
    logic                valid;
    logic                ready;
    rlst_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/run_length_style_table_unit.sv @@
// ----------------------------------------------------------------------------
// run_length_style_table_unit
// Line style table held as (style, length) runs plus an endless tail style.
// ----------------------------------------------------------------------------
// One request at a time. Query and overlay take longer the more runs they
// walk; their pace is set by the single registered read port of the run
// memory, which a small sequencer steps through one run at a time. Overlay
// writes the new table into the spare half of a double-buffered memory and
// swaps halves on success, so a rejected overlay leaves the table untouched.
// Results sit in an output register; no clearing pass is needed after reset.
module run_length_style_table_unit #(
    parameter int MAX_RUNS = 64
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rlst_in_if.sink   i_in,
    rlst_out_if.source o_out
);

    localparam int IW = $clog2(MAX_RUNS);
    localparam int CW = $clog2(MAX_RUNS + 1);
    localparam int LW = rlst_pkg::LEN_W;
    localparam int SW = rlst_pkg::STYLE_W;
    localparam int PW = rlst_pkg::COL_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LDW   = 4'd1;
    localparam logic [3:0] S_APP   = 4'd2;
    localparam logic [3:0] S_QRY   = 4'd3;
    localparam logic [3:0] S_PRE   = 4'd4;
    localparam logic [3:0] S_PAINT = 4'd5;
    localparam logic [3:0] S_SKIP  = 4'd6;
    localparam logic [3:0] S_REST  = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    rlst_pkg::t_run r_mem [2][MAX_RUNS];
    rlst_pkg::t_run r_rd;

    logic [3:0]    r_state, n_state, r_ret, n_ret;
    logic [CW-1:0] r_count, n_count, r_nx_cnt, n_nx_cnt, r_idx, n_idx;
    logic          r_bank, n_bank;
    logic [SW-1:0] r_tail, n_tail;
    logic          r_ov, n_ov;
    logic          r_pend_v, n_pend_v;

    rlst_pkg::t_run      r_pend, n_pend;
    rlst_pkg::t_out_item r_out, n_out;
    logic [SW-1:0]       r_newtail, n_newtail, r_cur_sty, n_cur_sty;
    logic [LW-1:0]       r_cur_len, n_cur_len;
    logic [PW-1:0]       r_start, n_start, r_skip, n_skip;
    rlst_pkg::t_in_item  r_req, n_req;
    logic [SW-1:0]       r_res_sty, n_res_sty;
    logic                r_status, n_status;

    logic           wr_en, wr_bank;
    logic [IW-1:0]  wr_idx;
    rlst_pkg::t_run wr_data;

    logic          push_en, push_fail;
    logic [SW-1:0] push_sty;
    logic [LW-1:0] push_len;
    logic [LW:0]   push_sum;
    logic [LW-1:0] start_x, skip_x;
    logic [CW-1:0] last_idx;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    assign start_x  = LW'(r_start);
    assign skip_x   = LW'(r_skip);
    assign last_idx = r_count - CW'(1);
    assign push_sum = {1'b0, r_pend.len} + {1'b0, push_len};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_bank][wr_idx] <= wr_data;
        end
        r_rd <= r_mem[r_bank][n_idx[IW-1:0]];
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_count   = r_count;
        n_nx_cnt  = r_nx_cnt;
        n_idx     = r_idx;
        n_bank    = r_bank;
        n_tail    = r_tail;
        n_ov      = r_ov;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_out     = r_out;
        n_newtail = r_newtail;
        n_cur_sty = r_cur_sty;
        n_cur_len = r_cur_len;
        n_start   = r_start;
        n_skip    = r_skip;
        n_req     = r_req;
        n_res_sty = r_res_sty;
        n_status  = r_status;
        wr_en     = 1'b0;
        wr_bank   = r_bank;
        wr_idx    = '0;
        wr_data   = r_pend;
        push_en   = 1'b0;
        push_sty  = r_cur_sty;
        push_len  = r_cur_len;
        push_fail = 1'b0;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_req     = i_in.data;
                    n_res_sty = '0;
                    n_status  = rlst_pkg::ST_DONE;
                    n_idx     = '0;
                    n_start   = i_in.data.position;
                    case (i_in.data.func)
                        rlst_pkg::FUNC_APPEND: begin
                            if (i_in.data.span == '0) begin
                                n_state = S_DONE;
                            end else if (r_count == '0) begin
                                wr_en   = 1'b1;
                                wr_idx  = '0;
                                wr_data = {i_in.data.style_in, LW'(i_in.data.span)};
                                n_count = CW'(1);
                                n_state = S_DONE;
                            end else begin
                                n_idx   = last_idx;
                                n_ret   = S_APP;
                                n_state = S_LDW;
                            end
                        end
                        rlst_pkg::FUNC_OVERLAY: begin
                            n_nx_cnt  = '0;
                            n_pend_v  = 1'b0;
                            n_newtail = r_tail;
                            n_ret     = S_PRE;
                            n_state   = S_LDW;
                        end
                        rlst_pkg::FUNC_QUERY: begin
                            n_ret   = S_QRY;
                            n_state = S_LDW;
                        end
                        default: begin
                            n_count = '0;
                            n_tail  = i_in.data.style_in;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LDW: begin
                if (r_idx < r_count) begin
                    n_cur_len = r_rd.len;
                    n_cur_sty = r_rd.style;
                end else begin
                    n_cur_len = '0;
                    n_cur_sty = r_tail;
                end
                n_state = r_ret;
            end
            S_APP: begin
                n_state = S_DONE;
                wr_idx  = last_idx[IW-1:0];
                if (r_cur_sty == r_req.style_in) begin
                    if (push_sum_app(r_cur_len, r_req.span)) begin
                        n_status = rlst_pkg::ST_REJECTED;
                    end else begin
                        wr_en   = 1'b1;
                        wr_data = {r_cur_sty, r_cur_len + LW'(r_req.span)};
                    end
                end else if (r_count >= CW'(MAX_RUNS)) begin
                    n_status = rlst_pkg::ST_REJECTED;
                end else begin
                    wr_en   = 1'b1;
                    wr_idx  = r_count[IW-1:0];
                    wr_data = {r_req.style_in, LW'(r_req.span)};
                    n_count = r_count + CW'(1);
                end
            end
            S_QRY: begin
                if (r_cur_len == '0) begin
                    n_res_sty = r_tail;
                    n_state   = S_DONE;
                end else if (start_x < r_cur_len) begin
                    n_res_sty = r_cur_sty;
                    n_state   = S_DONE;
                end else begin
                    n_start = r_start - r_cur_len[PW-1:0];
                    n_idx   = r_idx + CW'(1);
                    n_state = S_LDW;
                end
            end
            S_PRE: begin
                n_state = S_PAINT;
                if (r_cur_len != '0 && r_cur_len <= start_x) begin
                    push_en = 1'b1;
                    n_start = r_start - r_cur_len[PW-1:0];
                    n_idx   = r_idx + CW'(1);
                    n_state = S_LDW;
                end else if (r_cur_len != '0 && r_start != '0) begin
                    push_en   = 1'b1;
                    push_len  = start_x;
                    n_cur_len = r_cur_len - start_x;
                    n_start   = '0;
                end else if (r_start != '0) begin
                    push_en  = 1'b1;
                    push_sty = r_tail;
                    push_len = start_x;
                    n_start  = '0;
                end
            end
            S_PAINT: begin
                if (r_req.span == '0) begin
                    n_newtail = r_req.style_in;
                    n_state   = S_FLUSH;
                end else begin
                    push_en  = 1'b1;
                    push_sty = r_req.style_in;
                    push_len = LW'(r_req.span);
                    n_skip   = r_req.span;
                    n_ret    = S_SKIP;
                    n_state  = S_SKIP;
                end
            end
            S_SKIP: begin
                n_state = S_REST;
                if (r_cur_len != '0 && r_skip != '0) begin
                    if (r_cur_len <= skip_x) begin
                        n_skip  = r_skip - r_cur_len[PW-1:0];
                        n_idx   = r_idx + CW'(1);
                        n_state = S_LDW;
                    end else begin
                        n_cur_len = r_cur_len - skip_x;
                        n_skip    = '0;
                    end
                end
            end
            S_REST: begin
                if (r_cur_len != '0) begin
                    push_en = 1'b1;
                    n_idx   = r_idx + CW'(1);
                    n_ret   = S_REST;
                    n_state = S_LDW;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                wr_bank = ~r_bank;
                wr_idx  = last_nx(r_nx_cnt);
                wr_en   = r_pend_v;
                n_bank  = ~r_bank;
                n_count = r_nx_cnt;
                n_tail  = r_newtail;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_ov            = 1'b1;
                    n_out.style_out = r_res_sty;
                    n_out.status    = r_status;
                    n_out.runs_used = rlst_pkg::USED_W'(r_count);
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_en) begin
            if (r_pend_v && r_pend.style == push_sty) begin
                if (push_sum[LW]) begin
                    push_fail = 1'b1;
                end else begin
                    n_pend.len = push_sum[LW-1:0];
                end
            end else if (r_nx_cnt >= CW'(MAX_RUNS)) begin
                push_fail = 1'b1;
            end else begin
                wr_en    = r_pend_v;
                wr_bank  = ~r_bank;
                wr_idx   = last_nx(r_nx_cnt);
                wr_data  = r_pend;
                n_pend   = {push_sty, push_len};
                n_pend_v = 1'b1;
                n_nx_cnt = r_nx_cnt + CW'(1);
            end
            if (push_fail) begin
                n_status = rlst_pkg::ST_REJECTED;
                n_state  = S_DONE;
            end
        end
    end

    function automatic logic push_sum_app(input logic [LW-1:0] a, input logic [PW-1:0] b);
        logic [LW:0] s;
        s = {1'b0, a} + (LW + 1)'(b);
        return s[LW];
    endfunction

    function automatic logic [IW-1:0] last_nx(input logic [CW-1:0] c);
        logic [CW-1:0] d;
        d = c - CW'(1);
        return d[IW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_count  <= '0;
            r_bank   <= 1'b0;
            r_tail   <= '0;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_nx_cnt <= '0;
            r_idx    <= '0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_count  <= n_count;
            r_bank   <= n_bank;
            r_tail   <= n_tail;
            r_ov     <= n_ov;
            r_pend_v <= n_pend_v;
            r_nx_cnt <= n_nx_cnt;
            r_idx    <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend    <= n_pend;
        r_out     <= n_out;
        r_newtail <= n_newtail;
        r_cur_sty <= n_cur_sty;
        r_cur_len <= n_cur_len;
        r_start   <= n_start;
        r_skip    <= n_skip;
        r_req     <= n_req;
        r_res_sty <= n_res_sty;
        r_status  <= n_status;
    end

endmodule
